FILE: rtl/oft_pkg.sv
// oft_pkg: shared types and constants for the OBJ field tokenizer.
// No dependencies; imported by every module under rtl/.
package oft_pkg;

    localparam int LINE_W = 32;
    localparam int LEN_W  = 13;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef enum logic [2:0] {
        MODE_LINE_START = 3'd0,
        MODE_SKIP_LINE  = 3'd1,
        MODE_FIELD      = 3'd2,
        MODE_SKIP_WHITE = 3'd3,
        MODE_EOF        = 3'd4,
        MODE_ERROR      = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_END   = 3'd1,
        KIND_EOL   = 3'd2,
        KIND_EOF   = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         fbyte;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
        logic               last;
    } result_t;

    localparam result_t RESULT_ZERO = '{
        kind: KIND_BYTE, fbyte: 8'd0, length: '0, line: '0, last: 1'b0
    };

    function automatic logic [LINE_W-1:0] sat_inc(input logic [LINE_W-1:0] v);
        sat_inc = (v == {LINE_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

FILE: rtl/obj_field_tokenizer.sv
// obj_field_tokenizer: top level of the OBJ text field tokenizer.
// Depends on oft_pkg, oft_scan_core and oft_out_queue.
//
// Splits a byte stream into whitespace-separated fields, one byte per beat on
// s_text_byte. Field bytes stream out as they arrive; a space, tab, newline or
// byte 0 closes the field with its length. '#' at line start drops the rest of
// the line; a backslash escapes only a following backslash or newline (an
// escaped newline joins lines). Each result beat carries kind, byte, length,
// the line number and a last flag on the final result of its input byte. A
// field reaching FIELD_BYTES bytes gives one format error beat, then all input
// is dropped until reset. Throughput is one byte per cycle while m_ready is
// high and no byte yields two beats: state and results are registered at
// the accepting edge, the results into a two-entry output register that
// shows them in the next cycle. A byte closing a field with end of line or
// end of file yields two beats and holds s_ready low while the second drains;
// m_ready low stalls s_ready once the output register cannot empty that cycle.
module obj_field_tokenizer
    import oft_pkg::*;
#(
    parameter int FIELD_BYTES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input byte channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_text_byte,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_token_kind,
    output logic [7:0]        m_field_byte,
    output logic [LEN_W-1:0]  m_field_length,
    output logic [LINE_W-1:0] m_line_number,
    output logic              m_last_result
);

    logic       in_fire;
    result_t    res0;
    result_t    res1;
    logic [1:0] res_cnt;
    result_t    head;

    // a beat is taken only when the output register will be empty
    assign in_fire = s_valid && s_ready;

    oft_scan_core #(
        .FIELD_BYTES(FIELD_BYTES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .text_byte(s_text_byte),
        .res0     (res0),
        .res1     (res1),
        .res_cnt  (res_cnt)
    );

    oft_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt),
        .in_ready(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_token_kind   = head.kind;
    assign m_field_byte   = head.fbyte;
    assign m_field_length = head.length;
    assign m_line_number  = head.line;
    assign m_last_result  = head.last;

endmodule

FILE: rtl/oft_scan_core.sv
// oft_scan_core: tokenizer state and per-byte result generation.
// Depends on oft_pkg. Produces up to two results per accepted byte.
module oft_scan_core
    import oft_pkg::*;
#(
    parameter int FIELD_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] text_byte,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_cnt
);

    localparam int CW = $clog2(FIELD_BYTES + 1);
    localparam logic [CW-1:0] FIELD_MAX = CW'(FIELD_BYTES);

    mode_t            mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic             lap_reg, lap_next;

    always_comb begin
        logic          esc;
        logic          white;
        logic [CW-1:0] inc;
        mode_next = mode_reg;
        esc_next  = esc_reg;
        cnt_next  = cnt_reg;
        line_next = line_reg;
        lap_next  = lap_reg;
        res0      = RESULT_ZERO;
        res1      = RESULT_ZERO;
        res_cnt   = 2'd0;
        esc       = esc_reg;
        white     = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
        inc       = cnt_reg + 1'b1;

        if (mode_reg inside {MODE_LINE_START, MODE_SKIP_LINE, MODE_FIELD,
                             MODE_SKIP_WHITE, MODE_EOF}) begin
            if (lap_reg) begin
                line_next = sat_inc(line_next);
                lap_next  = 1'b0;
            end
            if (text_byte == CH_BSL && !esc_reg) begin
                esc_next = 1'b1;
            end else begin
                esc_next = 1'b0;
                // mode dispatch
                case (mode_reg)
                    MODE_LINE_START: begin
                        if (white) begin
                        end else if (text_byte == CH_LF) begin
                            line_next = sat_inc(line_next);
                        end else if (text_byte == CH_NUL) begin
                            res0.kind = KIND_EOF;
                            res0.line = line_next;
                            res_cnt   = 2'd1;
                        end else if (text_byte == CH_HASH) begin
                            mode_next = MODE_SKIP_LINE;
                        end else begin
                            mode_next = MODE_FIELD;
                        end
                    end
                    MODE_SKIP_LINE: begin
                        if (text_byte == CH_LF) begin
                            line_next = sat_inc(line_next);
                            if (!esc) mode_next = MODE_LINE_START;
                        end else if (text_byte == CH_NUL) begin
                            res0.kind = KIND_EOF;
                            res0.line = line_next;
                            res_cnt   = 2'd1;
                        end
                    end
                    MODE_SKIP_WHITE: begin
                        if (white) begin
                        end else if (text_byte == CH_LF) begin
                            if (esc) begin
                                line_next = sat_inc(line_next);
                            end else begin
                                res0.kind = KIND_EOL;
                                res0.line = line_next;
                                res_cnt   = 2'd1;
                                lap_next  = 1'b1;
                                mode_next = MODE_LINE_START;
                            end
                        end else if (text_byte == CH_NUL) begin
                            res0.kind = KIND_EOF;
                            res0.line = line_next;
                            res_cnt   = 2'd1;
                            mode_next = MODE_LINE_START;
                        end else begin
                            mode_next = MODE_FIELD;
                        end
                    end
                    MODE_EOF: begin
                        if (text_byte == CH_NUL) begin
                            res0.kind = KIND_EOF;
                            res0.line = line_next;
                            res_cnt   = 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase

                // field handling, also for the byte that opened the field
                if (mode_next == MODE_FIELD) begin
                    res0.line = line_next;
                    if (white || text_byte == CH_LF || text_byte == CH_NUL) begin
                        res0.kind   = KIND_END;
                        res0.length = LEN_W'(cnt_reg);
                        res_cnt     = 2'd1;
                        cnt_next    = '0;
                        if (white) begin
                            mode_next = MODE_SKIP_WHITE;
                        end else if (text_byte == CH_LF) begin
                            if (esc) begin
                                lap_next  = 1'b1;
                                mode_next = MODE_SKIP_WHITE;
                            end else begin
                                line_next = sat_inc(line_next);
                                res1.kind = KIND_EOL;
                                res1.line = line_next;
                                res_cnt   = 2'd2;
                                mode_next = MODE_LINE_START;
                            end
                        end else begin
                            res1.kind = KIND_EOF;
                            res1.line = line_next;
                            res_cnt   = 2'd2;
                            mode_next = MODE_EOF;
                        end
                    end else if (inc >= FIELD_MAX) begin
                        res0.kind = KIND_ERROR;
                        res_cnt   = 2'd1;
                        cnt_next  = '0;
                        mode_next = MODE_ERROR;
                    end else begin
                        res0.kind  = KIND_BYTE;
                        res0.fbyte = text_byte;
                        res_cnt    = 2'd1;
                        cnt_next   = inc;
                    end
                end
            end
        end

        if (res_cnt == 2'd1) res0.last = 1'b1;
        if (res_cnt == 2'd2) res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LINE_START;
            esc_reg  <= 1'b0;
            cnt_reg  <= '0;
            line_reg <= '0;
            lap_reg  <= 1'b0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            cnt_reg  <= cnt_next;
            line_reg <= line_next;
            lap_reg  <= lap_next;
        end
    end

endmodule

FILE: rtl/oft_out_queue.sv
// oft_out_queue: two-entry result register between the core and the m_ side.
// Depends on oft_pkg. Takes a new beat whenever all held results drain this cycle.
module oft_out_queue
    import oft_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  result_t    res0,
    input  result_t    res1,
    input  logic [1:0] res_cnt,
    output logic       in_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    head
);

    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       take;
    logic [1:0] rem;

    assign m_valid  = (cnt_reg != 2'd0);
    assign take     = m_valid && m_ready;
    assign rem      = cnt_reg - {1'b0, take};
    assign in_ready = (rem == 2'd0);
    assign head     = head_reg;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = rem;
        if (in_fire) begin
            head_next = res0;
            tail_next = res1;
            cnt_next  = res_cnt;
        end else if (cnt_reg == 2'd2 && take) begin
            head_next = tail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
